/* rtl/efla_pkg.sv */
// ----------------------------------------------------------------------------
// efla_pkg
// Shared constants and types of the extent free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

  // Table geometry.
  localparam int MAX_EXTENTS = 64;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

  // Sector and total widths.
  localparam int SEC_W = 24;
  localparam int TOT_W = 25;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 136;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_OVERLAP = 2'd3;

  // Request kinds.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Operations applied by the cell row to its stored entries.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_SET,
    OP_INS,
    OP_REM
  } tbl_op_t;

  // Command from the sequencer to every cell.
  typedef struct packed {
    tbl_op_t            op;
    logic [IDX_W-1:0]   idx;
    logic [SEC_W-1:0]   s;
    logic [SEC_W-1:0]   l;
    logic               scan_load;
    logic               scan_shift;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/efla_cell.sv */
// ----------------------------------------------------------------------------
// efla_cell
// A table entry and its scan chain copy. The entry shifts toward its neighbors
// on insert and remove; on a shift the scan copy moves one place down a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_cell (
  input  wire                          clk,
  input  efla_pkg::cell_cmd_t          cmd,
  input  wire [efla_pkg::IDX_W-1:0]    my_idx,
  input  wire [efla_pkg::SEC_W-1:0]    prev_s,
  input  wire [efla_pkg::SEC_W-1:0]    prev_l,
  input  wire [efla_pkg::SEC_W-1:0]    next_s,
  input  wire [efla_pkg::SEC_W-1:0]    next_l,
  input  wire [efla_pkg::SEC_W-1:0]    scan_in_s,
  input  wire [efla_pkg::SEC_W-1:0]    scan_in_l,
  output logic [efla_pkg::SEC_W-1:0]   ent_s,
  output logic [efla_pkg::SEC_W-1:0]   ent_l,
  output logic [efla_pkg::SEC_W-1:0]   scan_s,
  output logic [efla_pkg::SEC_W-1:0]   scan_l
);

  logic [efla_pkg::SEC_W-1:0] ent_s_r, ent_s_nxt;
  logic [efla_pkg::SEC_W-1:0] ent_l_r, ent_l_nxt;
  logic [efla_pkg::SEC_W-1:0] scan_s_r, scan_s_nxt;
  logic [efla_pkg::SEC_W-1:0] scan_l_r, scan_l_nxt;

  // Entry update for the current table operation.
  always_comb begin
    ent_s_nxt = ent_s_r;
    ent_l_nxt = ent_l_r;
    unique case (cmd.op)
      efla_pkg::OP_SET: begin
        if (my_idx == cmd.idx) begin
          ent_s_nxt = cmd.s;
          ent_l_nxt = cmd.l;
        end
      end
      efla_pkg::OP_INS: begin
        if (my_idx == cmd.idx) begin
          ent_s_nxt = cmd.s;
          ent_l_nxt = cmd.l;
        end else if (my_idx > cmd.idx) begin
          ent_s_nxt = prev_s;
          ent_l_nxt = prev_l;
        end
      end
      efla_pkg::OP_REM: begin
        if (my_idx >= cmd.idx) begin
          ent_s_nxt = next_s;
          ent_l_nxt = next_l;
        end
      end
      default: begin
      end
    endcase
  end

  // Scan copy: loaded from the entry, then shifted toward cell zero.
  always_comb begin
    scan_s_nxt = scan_s_r;
    scan_l_nxt = scan_l_r;
    if (cmd.scan_load) begin
      scan_s_nxt = ent_s_r;
      scan_l_nxt = ent_l_r;
    end else if (cmd.scan_shift) begin
      scan_s_nxt = scan_in_s;
      scan_l_nxt = scan_in_l;
    end
  end

  always_ff @(posedge clk) begin
    ent_s_r  <= ent_s_nxt;
    ent_l_r  <= ent_l_nxt;
    scan_s_r <= scan_s_nxt;
    scan_l_r <= scan_l_nxt;
  end

  assign ent_s  = ent_s_r;
  assign ent_l  = ent_l_r;
  assign scan_s = scan_s_r;
  assign scan_l = scan_l_r;

endmodule

`default_nettype wire

/* rtl/efla_ctrl.sv */
// ----------------------------------------------------------------------------
// efla_ctrl
// Request sequencer. Runs the search passes over the head of the scan chain,
// issues table operations to the cells and keeps the counters and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_ctrl (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [efla_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [efla_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                        out_tuser,
  input  wire [efla_pkg::SEC_W-1:0]         head_s,
  input  wire [efla_pkg::SEC_W-1:0]         head_l,
  input  wire [efla_pkg::SEC_W-1:0]         head1_s,
  input  wire [efla_pkg::SEC_W-1:0]         head1_l,
  output efla_pkg::cell_cmd_t               cmd
);

  localparam int SW = efla_pkg::SEC_W;
  localparam int TW = efla_pkg::TOT_W;
  localparam int CW = efla_pkg::CNT_W;
  localparam int IW = efla_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_LOAD, S_SCAN, S_ACT1, S_ACT2, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    P_HINT, P_EXACT_M, P_FIT_M, P_EXACT, P_FIT, P_BIG, P_FREE
  } pass_t;

  state_t state_r;
  pass_t  pass_r;

  // Request registers.
  logic          func_r, md_r;
  logic [SW-1:0] rs_r, n_r, ms_r, hs_r, hc_r;
  logic [TW-1:0] contig_r, mn_r, fe_r;

  // Block state and scan bookkeeping.
  logic [CW-1:0] count_r, i_r;
  logic [TW-1:0] free_r;
  logic [IW-1:0] best_idx_r;
  logic [SW-1:0] best_s_r, best_l_r;

  // Pending operation and result.
  efla_pkg::cell_cmd_t op1_r, op2_r;
  logic [SW-1:0] gs_r, gc_r, ts_r, tc_r, amt_r;
  logic          add_r, changed_r;
  logic [1:0]    stat_r;

  // Output register.
  logic          out_valid_r;
  logic [1:0]    o_stat_r;
  logic [SW-1:0] o_gs_r, o_gc_r, o_ts_r, o_tc_r;
  logic [TW-1:0] o_free_r;
  logic [CW-1:0] o_cnt_r;
  logic          o_dirty_r;

  // Evaluation of the entry at the head of the scan chain.
  logic          at_end, full, mz, has_next, merge;
  logic [SW-1:0] mcur, num, newlen;
  logic [TW-1:0] e;
  logic [IW-1:0] i_idx;
  logic          ev_hit, ev_fail, ev_miss;
  logic [1:0]    ev_stat;
  efla_pkg::cell_cmd_t ev_op1, ev_op2;
  logic [SW-1:0] ev_gs, ev_gc, ev_ts, ev_tc, ev_amt;
  logic          ev_add;
  pass_t         pass_nxt;

  assign at_end   = (i_r >= count_r);
  assign full     = (count_r >= CW'(efla_pkg::MAX_EXTENTS));
  assign e        = {1'b0, head_s} + {1'b0, head_l};
  assign i_idx    = i_r[IW-1:0];
  assign mcur     = (pass_r == P_EXACT_M || pass_r == P_FIT_M) ? ms_r : '0;
  assign mz       = (mcur != '0);
  assign num      = (n_r < head_l) ? n_r : head_l;
  assign has_next = (CW'(i_r + 1'b1) < count_r);
  assign merge    = has_next && ({1'b0, head1_s} == fe_r);
  assign newlen   = SW'(head_l + n_r + (merge ? head1_l : '0));

  always_comb begin
    ev_hit  = 1'b0;
    ev_fail = 1'b0;
    ev_miss = 1'b0;
    ev_stat = efla_pkg::ST_OK;
    ev_op1  = '{op: efla_pkg::OP_NOP, idx: i_idx, s: '0, l: '0,
                scan_load: 1'b0, scan_shift: 1'b0};
    ev_op2  = ev_op1;
    ev_gs   = '0;
    ev_gc   = '0;
    ev_ts   = '0;
    ev_tc   = '0;
    ev_amt  = '0;
    ev_add  = 1'b0;
    case (pass_r)
      // Extend the hint from the entry that starts right after it.
      P_HINT: begin
        if (at_end) begin
          ev_miss = 1'b1;
        end else if ({1'b0, head_s} == contig_r) begin
          ev_hit     = 1'b1;
          ev_op1.op  = (head_l == num) ? efla_pkg::OP_REM : efla_pkg::OP_SET;
          ev_op1.s   = head_s + num;
          ev_op1.l   = head_l - num;
          ev_ts      = head_s;
          ev_tc      = num;
          ev_gs      = hs_r;
          ev_gc      = hc_r + num;
          ev_amt     = num;
        end
      end
      // Exact-size extent, at the minimum sector when one is given.
      P_EXACT_M, P_EXACT: begin
        if (at_end) begin
          ev_miss = 1'b1;
        end else if (!(mz && {1'b0, mcur} >= e) && head_l == n_r &&
                     (!mz || mcur == head_s)) begin
          ev_hit    = 1'b1;
          ev_op1.op = efla_pkg::OP_REM;
          ev_gs     = head_s;
          ev_gc     = n_r;
          ev_ts     = head_s;
          ev_tc     = n_r;
          ev_amt    = n_r;
        end
      end
      // First fit; with a minimum sector, split the entry that holds it.
      P_FIT_M, P_FIT: begin
        if (at_end) begin
          ev_miss = 1'b1;
        end else if (mz && {1'b0, mcur} >= e) begin
          ev_miss = 1'b0;
        end else if (mz && mcur >= head_s) begin
          if (e >= mn_r) begin
            if (mcur == head_s) begin
              ev_hit    = 1'b1;
              ev_op1.op = (head_l == n_r) ? efla_pkg::OP_REM : efla_pkg::OP_SET;
              ev_op1.s  = head_s + n_r;
              ev_op1.l  = head_l - n_r;
            end else if (mn_r != e) begin
              if (full) begin
                ev_fail = 1'b1;
                ev_stat = efla_pkg::ST_FULL;
              end else begin
                ev_hit     = 1'b1;
                ev_op1.op  = efla_pkg::OP_SET;
                ev_op1.s   = head_s;
                ev_op1.l   = mcur - head_s;
                ev_op2.op  = efla_pkg::OP_INS;
                ev_op2.idx = i_idx + 1'b1;
                ev_op2.s   = mn_r[SW-1:0];
                ev_op2.l   = SW'(e - mn_r);
              end
            end else begin
              ev_hit    = 1'b1;
              ev_op1.op = efla_pkg::OP_SET;
              ev_op1.s  = head_s;
              ev_op1.l  = head_l - n_r;
            end
            ev_gs  = mcur;
            ev_gc  = n_r;
            ev_ts  = mcur;
            ev_tc  = n_r;
            ev_amt = n_r;
          end
        end else if (head_l >= n_r) begin
          ev_hit    = 1'b1;
          ev_op1.op = (head_l == n_r) ? efla_pkg::OP_REM : efla_pkg::OP_SET;
          ev_op1.s  = head_s + n_r;
          ev_op1.l  = head_l - n_r;
          ev_gs     = head_s;
          ev_gc     = n_r;
          ev_ts     = head_s;
          ev_tc     = n_r;
          ev_amt    = n_r;
        end
      end
      // Largest extent as a partial grant, tracked while scanning.
      P_BIG: begin
        if (at_end) begin
          if (count_r == '0) begin
            ev_fail = 1'b1;
            ev_stat = efla_pkg::ST_NONE;
          end else begin
            ev_hit     = 1'b1;
            ev_op1.op  = efla_pkg::OP_REM;
            ev_op1.idx = best_idx_r;
            ev_gs      = best_s_r;
            ev_gc      = best_l_r;
            ev_ts      = best_s_r;
            ev_tc      = best_l_r;
            ev_amt     = best_l_r;
          end
        end
      end
      // Free: merge with neighbors or insert in order.
      P_FREE: begin
        if (at_end || fe_r < {1'b0, head_s}) begin
          if (full) begin
            ev_fail = 1'b1;
            ev_stat = efla_pkg::ST_FULL;
          end else begin
            ev_hit    = 1'b1;
            ev_op1.op = efla_pkg::OP_INS;
            ev_op1.s  = rs_r;
            ev_op1.l  = n_r;
            ev_gs     = rs_r;
            ev_gc     = n_r;
            ev_amt    = n_r;
            ev_add    = 1'b1;
          end
        end else if (fe_r == {1'b0, head_s}) begin
          ev_hit    = 1'b1;
          ev_op1.op = efla_pkg::OP_SET;
          ev_op1.s  = rs_r;
          ev_op1.l  = head_l + n_r;
          ev_gs     = rs_r;
          ev_gc     = head_l + n_r;
          ev_amt    = n_r;
          ev_add    = 1'b1;
        end else if ({1'b0, rs_r} == e) begin
          if (has_next && {1'b0, head1_s} < fe_r) begin
            ev_fail = 1'b1;
            ev_stat = efla_pkg::ST_OVERLAP;
          end else begin
            ev_hit     = 1'b1;
            ev_op1.op  = efla_pkg::OP_SET;
            ev_op1.s   = head_s;
            ev_op1.l   = newlen;
            ev_op2.op  = merge ? efla_pkg::OP_REM : efla_pkg::OP_NOP;
            ev_op2.idx = i_idx + 1'b1;
            ev_gs      = head_s;
            ev_gc      = newlen;
            ev_amt     = n_r;
            ev_add     = 1'b1;
          end
        end else if ({1'b0, rs_r} < e) begin
          ev_fail = 1'b1;
          ev_stat = efla_pkg::ST_OVERLAP;
        end
      end
      default: begin
      end
    endcase
  end

  // Order of the allocate passes after a miss.
  always_comb begin
    case (pass_r)
      P_HINT:    pass_nxt = (ms_r != '0) ? P_EXACT_M : P_EXACT;
      P_EXACT_M: pass_nxt = P_FIT_M;
      P_FIT_M:   pass_nxt = P_EXACT;
      P_EXACT:   pass_nxt = P_FIT;
      default:   pass_nxt = P_BIG;
    endcase
  end

  // Command to the cell row.
  always_comb begin
    cmd = '{op: efla_pkg::OP_NOP, idx: '0, s: '0, l: '0,
            scan_load: 1'b0, scan_shift: 1'b0};
    unique case (state_r)
      S_LOAD: cmd.scan_load = 1'b1;
      S_SCAN: cmd.scan_shift = !ev_hit && !ev_fail && !ev_miss && !at_end;
      S_ACT1: cmd = op1_r;
      S_ACT2: cmd = op2_r;
      default: begin
      end
    endcase
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= P_HINT;
      count_r     <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r    <= in_tuser;
            rs_r      <= in_tdata[23:0];
            n_r       <= in_tdata[47:24];
            ms_r      <= in_tdata[71:48];
            hs_r      <= in_tdata[95:72];
            hc_r      <= in_tdata[119:96];
            md_r      <= in_tdata[120];
            contig_r  <= {1'b0, in_tdata[95:72]} + {1'b0, in_tdata[119:96]};
            mn_r      <= {1'b0, in_tdata[71:48]} + {1'b0, in_tdata[47:24]};
            fe_r      <= {1'b0, in_tdata[23:0]} + {1'b0, in_tdata[47:24]};
            gs_r      <= '0;
            gc_r      <= '0;
            ts_r      <= '0;
            tc_r      <= '0;
            changed_r <= 1'b1;
            stat_r    <= efla_pkg::ST_OK;
            state_r   <= S_START;
          end
        end
        S_START: begin
          if (func_r == efla_pkg::FUNC_ALLOC) begin
            if (n_r == '0) begin
              stat_r  <= efla_pkg::ST_NONE;
              state_r <= S_FIN;
            end else begin
              if (hs_r != '0 && hc_r != '0) begin
                pass_r <= P_HINT;
              end else if (ms_r != '0) begin
                pass_r <= P_EXACT_M;
              end else begin
                pass_r <= P_EXACT;
              end
              state_r <= S_LOAD;
            end
          end else if (rs_r == '0 || n_r == '0) begin
            changed_r <= 1'b0;
            state_r   <= S_FIN;
          end else if (fe_r > {1'b1, {SW{1'b0}}}) begin
            stat_r  <= efla_pkg::ST_OVERLAP;
            state_r <= S_FIN;
          end else begin
            pass_r  <= P_FREE;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          i_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (ev_fail) begin
            stat_r  <= ev_stat;
            state_r <= S_FIN;
          end else if (ev_hit) begin
            op1_r   <= ev_op1;
            op2_r   <= ev_op2;
            gs_r    <= ev_gs;
            gc_r    <= ev_gc;
            ts_r    <= ev_ts;
            tc_r    <= ev_tc;
            amt_r   <= ev_amt;
            add_r   <= ev_add;
            state_r <= S_ACT1;
          end else if (ev_miss) begin
            pass_r  <= pass_nxt;
            state_r <= S_LOAD;
          end else begin
            if (pass_r == P_BIG && (i_r == '0 || head_l > best_l_r)) begin
              best_idx_r <= i_idx;
              best_s_r   <= head_s;
              best_l_r   <= head_l;
            end
            i_r <= i_r + 1'b1;
          end
        end
        S_ACT1: begin
          if (op1_r.op == efla_pkg::OP_INS) begin
            count_r <= count_r + 1'b1;
          end else if (op1_r.op == efla_pkg::OP_REM) begin
            count_r <= count_r - 1'b1;
          end
          free_r  <= add_r ? free_r + {1'b0, amt_r} : free_r - {1'b0, amt_r};
          state_r <= (op2_r.op == efla_pkg::OP_NOP) ? S_FIN : S_ACT2;
        end
        S_ACT2: begin
          if (op2_r.op == efla_pkg::OP_INS) begin
            count_r <= count_r + 1'b1;
          end else if (op2_r.op == efla_pkg::OP_REM) begin
            count_r <= count_r - 1'b1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            o_stat_r    <= stat_r;
            o_gs_r      <= gs_r;
            o_gc_r      <= gc_r;
            o_ts_r      <= ts_r;
            o_tc_r      <= tc_r;
            o_free_r    <= free_r;
            o_cnt_r     <= count_r;
            o_dirty_r   <= (stat_r == efla_pkg::ST_OK) && changed_r && md_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_stat_r;
  assign out_tdata  = {7'd0, o_dirty_r, o_cnt_r, o_free_r, o_tc_r, o_ts_r, o_gc_r, o_gs_r};

endmodule

`default_nettype wire

/* rtl/extent_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// extent_free_list_allocator_top
// Sorted free-extent table with allocate and coalescing free.
//
//   Channel   Direction  Contents
//   in_*      slave      one allocate or free request per item
//   out_*     master     one result per request
//
// A request is captured and then decoded. Each search pass (up to six for
// allocate, one for free) loads the scan chain and walks it; one or two table
// update steps and the loading of the result follow. The scan walks the cell
// row's shift chain one entry per cycle. Reset is synchronous, active low,
// and empties the table at once.
// A stalled result waits in the output register; the next request is taken
// meanwhile and holds in its last cycle until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_free_list_allocator_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // req_start[23:0], req_count[47:24], min_sector[71:48], hint_start[95:72],
  // hint_count[119:96], mark_dirty[120], zero fill above.
  input  wire [efla_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[0].
  input  wire                              in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // grant_start[23:0], grant_count[47:24], taken_start[71:48],
  // taken_count[95:72], free_sectors[120:96], entries_used[127:121],
  // dirty_flag[128], zero fill above.
  output logic [efla_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0].
  output logic [1:0]                       out_tuser
);

  localparam int N = efla_pkg::MAX_EXTENTS;

  efla_pkg::cell_cmd_t cmd;

  logic [efla_pkg::SEC_W-1:0] ent_s  [N];
  logic [efla_pkg::SEC_W-1:0] ent_l  [N];
  logic [efla_pkg::SEC_W-1:0] scan_s [N];
  logic [efla_pkg::SEC_W-1:0] scan_l [N];

  // Sequencer.
  efla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .head_s     (scan_s[0]),
    .head_l     (scan_l[0]),
    .head1_s    (scan_s[1]),
    .head1_l    (scan_l[1]),
    .cmd        (cmd)
  );

  // Row of table cells, each linked to both neighbors.
  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [efla_pkg::SEC_W-1:0] p_s, p_l, n_s, n_l, sn_s, sn_l;
    if (j == 0) begin : g_first
      assign p_s = '0;
      assign p_l = '0;
    end else begin : g_mid
      assign p_s = ent_s[j-1];
      assign p_l = ent_l[j-1];
    end
    if (j == N - 1) begin : g_last
      assign n_s  = '0;
      assign n_l  = '0;
      assign sn_s = '0;
      assign sn_l = '0;
    end else begin : g_body
      assign n_s  = ent_s[j+1];
      assign n_l  = ent_l[j+1];
      assign sn_s = scan_s[j+1];
      assign sn_l = scan_l[j+1];
    end
    efla_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_idx    (efla_pkg::IDX_W'(j)),
      .prev_s    (p_s),
      .prev_l    (p_l),
      .next_s    (n_s),
      .next_l    (n_l),
      .scan_in_s (sn_s),
      .scan_in_l (sn_l),
      .ent_s     (ent_s[j]),
      .ent_l     (ent_l[j]),
      .scan_s    (scan_s[j]),
      .scan_l    (scan_l[j])
    );
  end

endmodule

`default_nettype wire

/* rtl/efla_checker.sv */
// ----------------------------------------------------------------------------
// efla_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [efla_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [1:0]                        out_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Requests are taken one at a time.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in work");

  // A failed request reports no extent.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != efla_pkg::ST_OK |-> out_tdata[95:0] == '0)
    else $error("failed request carries extent fields");

  // A full-table status only when the table is full.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == efla_pkg::ST_FULL |->
      out_tdata[127:121] == 7'(efla_pkg::MAX_EXTENTS))
    else $error("table full reported with free entries");

endmodule

bind extent_free_list_allocator_top efla_checker u_efla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser)
);

`default_nettype wire
